// ===== hdl/trial_division_primality_defines.svh =====
// ---------------------------------------------------------------------------
// Trial division primality: assertion macros
// Shared assertion forms, clocked on clk_i and quiet while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_DEFINES_SVH

// same-cycle implication
`define TDP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define TDP_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/tdp_pkg.sv =====
// ---------------------------------------------------------------------------
// Trial division primality: package
// Widths, defaults and the command/status bundles between control and data.
// ---------------------------------------------------------------------------
package tdp_pkg;

  // default operand width and fixed candidate port width
  localparam int TDP_WORD_WIDTH = 32;
  localparam int TDP_CAND_WIDTH = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture candidate, set divisor to three
    logic div_start;  // begin a remainder pass
    logic div_step;   // one restoring-division bit
    logic next_div;   // advance to the next odd divisor
  } tdp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial;        // decided without division
    logic trivial_prime;  // verdict for the trivial case
    logic in_range;       // divisor squared is at most the candidate
    logic div_last;       // final bit of the remainder pass
    logic rem_zero;       // remainder is zero
  } tdp_stat_t;

endpackage

// ===== hdl/tdp_dpath.sv =====
// ---------------------------------------------------------------------------
// Trial division primality: datapath
// Holds the candidate, the odd divisor and its square, and a bit-serial
// restoring remainder unit that produces one bit per cycle.
// ---------------------------------------------------------------------------
`include "trial_division_primality_defines.svh"

module tdp_dpath import tdp_pkg::*; #(
  parameter int WORD_WIDTH = TDP_WORD_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [TDP_CAND_WIDTH-1:0] candidate_i,
  input  tdp_cmd_t                  cmd_i,
  output tdp_stat_t                 stat_o
);

  localparam int CW = $clog2(WORD_WIDTH);

  logic [WORD_WIDTH-1:0] n_q, n_d;
  logic [WORD_WIDTH-1:0] d_q, d_d;
  logic [WORD_WIDTH+1:0] sq_q, sq_d;
  logic [WORD_WIDTH-1:0] rem_q, rem_d;
  logic [WORD_WIDTH-1:0] shift_q, shift_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, shift_q[WORD_WIDTH-1]};
  assign diff  = trial - {1'b0, d_q};

  // next-state logic
  always_comb begin
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      n_d  = WORD_WIDTH'(candidate_i);
      d_d  = WORD_WIDTH'(3);
      sq_d = (WORD_WIDTH+2)'(9);
    end
    if (cmd_i.div_start) begin
      rem_d   = '0;
      shift_d = n_q;
      cnt_d   = '0;
    end
    if (cmd_i.div_step) begin
      rem_d   = diff[WORD_WIDTH] ? trial[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
      shift_d = {shift_q[WORD_WIDTH-2:0], 1'b0};
      cnt_d   = cnt_q + CW'(1);
    end
    // (d+2)^2 = d^2 + 4d + 4
    if (cmd_i.next_div) begin
      d_d  = d_q + WORD_WIDTH'(2);
      sq_d = sq_q + {d_q, 2'b00} + (WORD_WIDTH+2)'(4);
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    shift_q <= shift_d;
  end

  // status back to the controller
  always_comb begin
    stat_o.trivial       = (n_q < WORD_WIDTH'(4)) || !n_q[0];
    stat_o.trivial_prime = (n_q == WORD_WIDTH'(2)) || (n_q == WORD_WIDTH'(3));
    stat_o.in_range      = sq_q <= {2'b00, n_q};
    stat_o.div_last      = cnt_q == CW'(WORD_WIDTH-1);
    stat_o.rem_zero      = rem_q == '0;
  end

  // checks
  `TDP_ASSERT_NXT(a_rem_below_div, cmd_i.div_step, rem_q < d_q, "remainder not below divisor")
  `TDP_ASSERT_IMP(a_div_odd, cmd_i.div_step, d_q[0], "divisor is even")
  `TDP_ASSERT_NXT(a_sq_grows, cmd_i.next_div, sq_q > $past(sq_q), "divisor square did not grow")

endmodule

// ===== hdl/tdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Trial division primality: controller
// Sequences classify, range check, remainder pass and test per divisor, and
// owns the output register.
// ---------------------------------------------------------------------------
`include "trial_division_primality_defines.svh"

module tdp_ctrl import tdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      prime_o,
  output tdp_cmd_t  cmd_o,
  input  tdp_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   verdict_q;
  logic   out_valid_q;
  logic   prime_q;
  logic   out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // commands decoded from state and status
  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_CHECK) && stat_i.in_range;
    cmd_o.div_step  = state_q == S_DIV;
    cmd_o.next_div  = (state_q == S_TEST) && !stat_i.rem_zero;
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      prime_q     <= 1'b0;
    end else begin
      // beat taken downstream; finish reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          if (stat_i.trivial) begin
            verdict_q <= stat_i.trivial_prime;
            state_q   <= S_FINISH;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat_i.in_range) begin
            state_q <= S_DIV;
          end else begin
            verdict_q <= 1'b1;
            state_q   <= S_FINISH;
          end
        end
        S_DIV: begin
          if (stat_i.div_last) begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          if (stat_i.rem_zero) begin
            verdict_q <= 1'b0;
            state_q   <= S_FINISH;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            prime_q     <= verdict_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `TDP_ASSERT_NXT(a_load_classify, cmd_o.load, state_q == S_CLASSIFY, "load did not classify")
  `TDP_ASSERT_NXT(a_div_stays, (state_q == S_DIV) && !stat_i.div_last, state_q == S_DIV, "cut short")
  `TDP_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q == S_FINISH), "no finish")

endmodule

// ===== hdl/trial_division_primality.sv =====
// ---------------------------------------------------------------------------
// Trial division primality
// Reports whether an unsigned candidate is prime by dividing by odd numbers
// from three while the divisor squared does not exceed the candidate.
// ---------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------
//   in      | input     | in_valid_i/in_stall_o   | candidate_i
//   out     | output    | out_valid_o/out_stall_i | prime_o
//
// Values below four and even values are decided at classify, without division.
// Odd candidates take a range check, a remainder pass and a test per odd divisor
// tried, the pass set by the bit-serial remainder unit (one quotient bit per
// cycle); the worst case is about 2^(WORD_WIDTH/2 - 1) divisors.
// One item at a time; a new beat is taken while an earlier result waits.
// No state survives between items; reset returns the controller to idle.
// ---------------------------------------------------------------------------
module trial_division_primality import tdp_pkg::*; #(
  parameter int WORD_WIDTH = TDP_WORD_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [TDP_CAND_WIDTH-1:0] candidate_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      prime_o
);

  tdp_cmd_t  cmd;
  tdp_stat_t stat;

  // sequencer
  tdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_o     (prime_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // divisor and remainder datapath
  tdp_dpath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
